>>> hdl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types, constants and the control store of the rc4 stream cipher core.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int KEY_REG_W       = 64;
  localparam int KEY_LEN_W       = 5;
  localparam int MAX_KEY_BYTES_D = 16;
  localparam int SBOX_DEPTH      = 256;
  localparam int BYTE_W          = 8;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  // input function codes
  localparam logic FUNC_REKEY  = 1'b0;
  localparam logic FUNC_CIPHER = 1'b1;

  typedef logic [3:0] pc_t;

  typedef enum logic [1:0] {
    RA_I_INC,
    RA_J_SUM,
    RA_T,
    RA_P
  } raddr_sel_t;

  typedef enum logic [1:0] {
    WA_I,
    WA_J,
    WA_P
  } waddr_sel_t;

  typedef enum logic [1:0] {
    WD_RDATA,
    WD_SI,
    WD_P
  } wdata_sel_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_STEP,
    IDX_CLR
  } idx_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_LOOP,
    JMP_END
  } jmp_t;

  typedef struct packed {
    raddr_sel_t ra_sel;
    logic       add_key;
    logic       we;
    waddr_sel_t wa_sel;
    wdata_sel_t wd_sel;
    idx_op_t    i_op;
    idx_op_t    j_op;
    logic       ld_si;
    logic       ld_sj;
    logic       p_inc;
    logic       k_inc;
    logic       emit;
    jmp_t       jmp;
    pc_t        target;
  } ctrl_word_t;

  // program entry points and steps
  localparam pc_t PC_PRGA0   = 4'd0;
  localparam pc_t PC_PRGA1   = 4'd1;
  localparam pc_t PC_PRGA2   = 4'd2;
  localparam pc_t PC_PRGA3   = 4'd3;
  localparam pc_t PC_PRGA4   = 4'd4;
  localparam pc_t PC_PRGA5   = 4'd5;
  localparam pc_t PC_FILL    = 4'd6;
  localparam pc_t PC_KSA0    = 4'd7;
  localparam pc_t PC_KSA1    = 4'd8;
  localparam pc_t PC_KSA2    = 4'd9;
  localparam pc_t PC_KSA3    = 4'd10;
  localparam pc_t PC_KSA_END = 4'd11;

  localparam ctrl_word_t CTRL_NOP = '{
    ra_sel:  RA_P,
    add_key: 1'b0,
    we:      1'b0,
    wa_sel:  WA_P,
    wd_sel:  WD_RDATA,
    i_op:    IDX_HOLD,
    j_op:    IDX_HOLD,
    ld_si:   1'b0,
    ld_sj:   1'b0,
    p_inc:   1'b0,
    k_inc:   1'b0,
    emit:    1'b0,
    jmp:     JMP_NEXT,
    target:  PC_PRGA0
  };

  // control store
  function automatic ctrl_word_t ucode(input pc_t pc);
    ctrl_word_t w;
    w = CTRL_NOP;
    unique case (pc)
      // keystream: i += 1, read s[i]
      PC_PRGA0: begin
        w.ra_sel = RA_I_INC;
        w.i_op   = IDX_STEP;
      end
      // j += s[i], read s[j]
      PC_PRGA1: begin
        w.ld_si  = 1'b1;
        w.ra_sel = RA_J_SUM;
        w.j_op   = IDX_STEP;
      end
      PC_PRGA2: begin
        w.ld_sj  = 1'b1;
        w.we     = 1'b1;
        w.wa_sel = WA_I;
        w.wd_sel = WD_RDATA;
      end
      PC_PRGA3: begin
        w.we     = 1'b1;
        w.wa_sel = WA_J;
        w.wd_sel = WD_SI;
      end
      PC_PRGA4: begin
        w.ra_sel = RA_T;
      end
      // address held so the read data survives an output stall
      PC_PRGA5: begin
        w.ra_sel = RA_T;
        w.emit   = 1'b1;
        w.jmp    = JMP_END;
      end
      PC_FILL: begin
        w.we     = 1'b1;
        w.wa_sel = WA_P;
        w.wd_sel = WD_P;
        w.p_inc  = 1'b1;
        w.jmp    = JMP_LOOP;
        w.target = PC_FILL;
      end
      PC_KSA0: begin
        w.ra_sel = RA_P;
      end
      PC_KSA1: begin
        w.ld_si   = 1'b1;
        w.ra_sel  = RA_J_SUM;
        w.add_key = 1'b1;
        w.j_op    = IDX_STEP;
      end
      PC_KSA2: begin
        w.we     = 1'b1;
        w.wa_sel = WA_P;
        w.wd_sel = WD_RDATA;
      end
      PC_KSA3: begin
        w.we     = 1'b1;
        w.wa_sel = WA_J;
        w.wd_sel = WD_SI;
        w.p_inc  = 1'b1;
        w.k_inc  = 1'b1;
        w.jmp    = JMP_LOOP;
        w.target = PC_KSA0;
      end
      PC_KSA_END: begin
        w.i_op = IDX_CLR;
        w.j_op = IDX_CLR;
        w.jmp  = JMP_END;
      end
      default: begin
        w.jmp = JMP_END;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hdl/rc4_ram.sv
// ----------------------------------------------------------------------------
// rc4_ram
// Generic simple dual-port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/rc4_useq.sv
// ----------------------------------------------------------------------------
// rc4_useq
// Step counter and control store: one control word per step, looped and
// terminated by the jump field.
// ----------------------------------------------------------------------------
module rc4_useq
  import rc4_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       func,
  input  logic       stall,
  input  logic       p_last,
  output logic       busy,
  output logic       step_en,
  output ctrl_word_t ctrl
);

  pc_t pc;
  pc_t pc_next;
  logic busy_next;

  assign ctrl    = busy ? ucode(pc) : CTRL_NOP;
  assign step_en = busy && !stall;

  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (start) begin
      pc_next   = (func == FUNC_CIPHER) ? PC_PRGA0 : PC_FILL;
      busy_next = 1'b1;
    end else if (step_en) begin
      unique case (ctrl.jmp)
        JMP_NEXT: pc_next = pc + 4'd1;
        JMP_LOOP: pc_next = p_last ? pc + 4'd1 : ctrl.target;
        JMP_END:  busy_next = 1'b0;
        default:  busy_next = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= PC_PRGA0;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("item started while the sequencer is busy");

  assert property (@(posedge clk) disable iff (rst)
    (step_en && ctrl.jmp == JMP_END) |=> !busy)
    else $error("sequencer did not stop at end of program");

  assert property (@(posedge clk) disable iff (rst)
    (busy && stall) |=> (busy && $stable(pc)))
    else $error("step counter moved during a stall");

endmodule

>>> hdl/rc4_stream_cipher_core.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// RC4 stream cipher: key schedule and keystream generation over one s-box ram,
// driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// cipher item: 6 sequencer steps after acceptance, result registered on the
//   last step, next item taken once the sequencer is idle (single s-box ram port pair)
// rekey item: 256 fill steps + 4 x 256 mixing steps + 1 final step, no result
// reset: indices cleared, key length 16, key bytes zero; s-box undefined
//   until the first rekey
module rc4_stream_cipher_core
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_D
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]           s_axis_tuser,   // [0] func
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] data_out
  output logic                 m_axis_tlast,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [KEY_REG_W-1:0] cfg_data
);

  localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);
  localparam int SB_AW = $clog2(SBOX_DEPTH);

  logic [MAX_KEY_BYTES-1:0][BYTE_W-1:0] key;
  logic [KEY_LEN_W-1:0] key_len;
  logic [KEY_LEN_W-1:0] eff_len;

  logic [SB_AW-1:0]  index_i;
  logic [SB_AW-1:0]  index_j;
  logic [SB_AW-1:0]  p;
  logic [KIDX_W-1:0] kidx;
  logic [BYTE_W-1:0] si;
  logic [BYTE_W-1:0] sj;
  logic [BYTE_W-1:0] data_byte;
  logic              last;

  logic              out_valid;
  logic [BYTE_W-1:0] data_out;
  logic              last_out;

  logic              s_fire;
  logic              busy;
  logic              step_en;
  logic              stall;
  ctrl_word_t        ctrl;

  logic              ram_we;
  logic [SB_AW-1:0]  ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [SB_AW-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [SB_AW-1:0]  j_sum;

  // ---------------- configuration ----------------
  for (genvar b = 0; b < MAX_KEY_BYTES; b++) begin : g_key
    localparam logic [1:0] KEY_REG = (b < 8) ? REG_KEY_LOW : REG_KEY_HIGH;
    always_ff @(posedge clk) begin
      if (rst) begin
        key[b] <= '0;
      end else if (cfg_we && cfg_index == KEY_REG) begin
        key[b] <= cfg_data[BYTE_W*(b%8) +: BYTE_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_len <= KEY_LEN_W'(16);
    end else if (cfg_we && cfg_index == REG_KEY_LEN) begin
      key_len <= cfg_data[KEY_LEN_W-1:0];
    end
  end

  // zero length acts as one, long keys saturate
  always_comb begin
    if (key_len == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_len > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = key_len;
    end
  end

  // ---------------- sequencer ----------------
  assign s_axis_tready = !busy;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign stall         = ctrl.emit && out_valid && !m_axis_tready;

  rc4_useq u_useq (
    .clk     (clk),
    .rst     (rst),
    .start   (s_fire),
    .func    (s_axis_tuser[0]),
    .stall   (stall),
    .p_last  (p == '1),
    .busy    (busy),
    .step_en (step_en),
    .ctrl    (ctrl)
  );

  // ---------------- datapath ----------------
  assign j_sum = index_j + ram_rdata + (ctrl.add_key ? key[kidx] : '0);

  always_comb begin
    case (ctrl.ra_sel)
      RA_I_INC: ram_raddr = index_i + SB_AW'(1);
      RA_J_SUM: ram_raddr = j_sum;
      RA_T:     ram_raddr = si + sj;
      default:  ram_raddr = p;
    endcase
    case (ctrl.wa_sel)
      WA_I:    ram_waddr = index_i;
      WA_J:    ram_waddr = index_j;
      default: ram_waddr = p;
    endcase
    case (ctrl.wd_sel)
      WD_RDATA: ram_wdata = ram_rdata;
      WD_SI:    ram_wdata = si;
      default:  ram_wdata = p;
    endcase
  end

  assign ram_we = ctrl.we && step_en;

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SBOX_DEPTH)
  ) u_sbox (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      index_i <= '0;
      index_j <= '0;
      p       <= '0;
      kidx    <= '0;
    end else if (s_fire) begin
      if (s_axis_tuser[0] == FUNC_REKEY) begin
        index_j <= '0;
        p       <= '0;
        kidx    <= '0;
      end
    end else if (step_en) begin
      case (ctrl.i_op)
        IDX_STEP: index_i <= index_i + SB_AW'(1);
        IDX_CLR:  index_i <= '0;
        default:  index_i <= index_i;
      endcase
      case (ctrl.j_op)
        IDX_STEP: index_j <= j_sum;
        IDX_CLR:  index_j <= '0;
        default:  index_j <= index_j;
      endcase
      if (ctrl.p_inc) begin
        p <= p + SB_AW'(1);
      end
      // key index wraps at the effective key length
      if (ctrl.k_inc) begin
        if (KEY_LEN_W'(kidx) == eff_len - KEY_LEN_W'(1)) begin
          kidx <= '0;
        end else begin
          kidx <= kidx + KIDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      data_byte <= s_axis_tdata;
      last      <= s_axis_tlast;
    end
    if (step_en && ctrl.ld_si) begin
      si <= ram_rdata;
    end
    if (step_en && ctrl.ld_sj) begin
      sj <= ram_rdata;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en && ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && ctrl.emit) begin
      data_out <= data_byte ^ ram_rdata;
      last_out <= last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = data_out;
  assign m_axis_tlast  = last_out;

  // ---------------- checks ----------------
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(step_en && ctrl.emit))
    else $error("item presented without a keystream step");

  assert property (@(posedge clk) disable iff (rst)
    (step_en && ctrl.jmp == JMP_END && !ctrl.emit) |=> (index_i == '0 && index_j == '0))
    else $error("indices not cleared after key schedule");

  assert property (@(posedge clk) disable iff (rst)
    (step_en && ctrl.jmp == JMP_LOOP && p == '1) |=> (p == '0))
    else $error("position counter did not wrap at end of pass");

  assert property (@(posedge clk) disable iff (rst)
    stall |-> !ram_we)
    else $error("s-box written during an output stall");

endmodule
